### hw/rtl/first_fit_extent_allocator_unit_assert.svh
// Assertion macros for the first-fit extent allocator.
// Used by first_fit_extent_allocator_unit.sv; no other dependencies.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FFEA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define FFEA_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

### hw/rtl/ffea_pkg.sv
// Shared constants and types for the first-fit extent allocator.
// No dependencies.
`default_nettype none
package ffea_pkg;
    localparam int MEMORY_UNITS = 32768;
    localparam int MAX_EXTENTS  = 64;
    localparam int ADDR_W = 15;
    localparam int SIZE_W = 16;
    localparam int IDX_W  = $clog2(MAX_EXTENTS);
    localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_SPACE    = 2'd1;
    localparam logic [1:0] ST_BAD_RELEASE = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL  = 2'd3;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // One table entry: start and length packed together.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] length;
    } extent_t;
endpackage
`default_nettype wire

### hw/rtl/ffea_table_ram.sv
// Extent table storage: one write port, one registered read port.
// Depends on ffea_pkg.
`default_nettype none
module ffea_table_ram (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [ffea_pkg::IDX_W-1:0] wr_addr,
    input  wire ffea_pkg::extent_t        wr_data,
    input  wire logic [ffea_pkg::IDX_W-1:0] rd_addr,
    output ffea_pkg::extent_t             rd_data
);
    ffea_pkg::extent_t mem [ffea_pkg::MAX_EXTENTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### hw/rtl/first_fit_extent_allocator_unit.sv
// First-fit extent allocator with coalescing, one item at a time.
// An item rejected on its fields alone goes straight to the result state; else the result waits
// for every table entry read in a scan (a release scans twice) and every entry moved.
// The longest case joins both sides near the table start with 64 extents.
// The next item is accepted in the cycle after the result is taken.
// Reset (aresetn low, synchronous) leaves one extent covering all memory; no clearing pass.
`default_nettype none
module first_fit_extent_allocator_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_operation,
    input  wire logic [ffea_pkg::ADDR_W-1:0]  s_block_address,
    input  wire logic [ffea_pkg::SIZE_W-1:0]  s_block_size,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_status,
    output logic [ffea_pkg::ADDR_W-1:0]       m_granted_address
);
`include "first_fit_extent_allocator_unit_assert.svh"

    localparam int IW = ffea_pkg::IDX_W;
    localparam int CW = ffea_pkg::CNT_W;
    localparam int AW = ffea_pkg::ADDR_W;
    localparam int SW = ffea_pkg::SIZE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;  // read issued for idx_reg
    localparam logic [3:0] S_CHECK = 4'd2;  // data for idx_reg available
    localparam logic [3:0] S_DECIDE= 4'd3;  // release: pos found, decide merge
    localparam logic [3:0] S_NEXTR = 4'd4;  // wait read of entry pos
    localparam logic [3:0] S_SHL   = 4'd5;  // drop: read k+1
    localparam logic [3:0] S_SHLW  = 4'd6;  // drop: write k
    localparam logic [3:0] S_SHR   = 4'd7;  // open: read k-1
    localparam logic [3:0] S_SHRW  = 4'd8;  // open: write k
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_PREVR = 4'd10; // wait read of entry pos-1

    logic [3:0]     state_reg, state_next;
    logic           op_reg;
    logic [AW-1:0]  addr_reg;
    logic [SW-1:0]  size_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;     // scan index / shift index
    logic [CW-1:0]  pos_reg, pos_next;     // stop point for shifting
    logic           phase_reg, phase_next; // release: 0 overlap scan, 1 pos scan
    logic           jp_reg, jp_next;
    logic [SW:0]    prevlen_reg, prevlen_next;
    ffea_pkg::extent_t ins_reg, ins_next;  // entry written at end of open shift
    logic [1:0]     st_reg, st_next;
    logic [AW-1:0]  ga_reg, ga_next;
    logic           mv_reg;

    logic           wr_en;
    logic [IW-1:0]  wr_addr, rd_addr;
    ffea_pkg::extent_t wr_data, rd_data;

    ffea_table_ram u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Reset value of entry 0 is written by the init state instead of per-entry flops.
    logic init_reg;

    logic [SW:0] rel_end;
    logic [SW:0] ext_end;
    assign rel_end = {2'b0, addr_reg} + {1'b0, size_reg};
    assign ext_end = {2'b0, rd_data.start} + {1'b0, rd_data.length};

    assign s_ready = (state_reg == S_IDLE) && !mv_reg && !init_reg;
    assign m_valid = mv_reg;
    assign m_status = st_reg;
    assign m_granted_address = ga_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        phase_next = phase_reg;
        jp_next = jp_reg;
        prevlen_next = prevlen_reg;
        ins_next = ins_reg;
        st_next = st_reg;
        ga_next = ga_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = rd_data;
        rd_addr = idx_reg[IW-1:0];
        if (init_reg) begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data.start = '0;
            wr_data.length = SW'(ffea_pkg::MEMORY_UNITS);
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    idx_next = '0;
                    phase_next = 1'b0;
                    st_next = ffea_pkg::ST_OK;
                    ga_next = '0;
                    if (s_operation == ffea_pkg::OP_ALLOC) begin
                        if (s_block_size == '0) begin
                            st_next = ffea_pkg::ST_NO_SPACE;
                            state_next = S_OUT;
                        end else begin
                            state_next = (count_reg == '0) ? S_OUT : S_SCAN;
                            if (count_reg == '0) st_next = ffea_pkg::ST_NO_SPACE;
                        end
                    end else begin
                        if (s_block_size == '0 || ({2'b0, s_block_address} +
                            {1'b0, s_block_size}) > (SW+1)'(ffea_pkg::MEMORY_UNITS)) begin
                            st_next = ffea_pkg::ST_BAD_RELEASE;
                            state_next = S_OUT;
                        end else if (count_reg == '0) begin
                            pos_next = '0;
                            jp_next = 1'b0;
                            state_next = S_DECIDE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                rd_addr = idx_reg[IW-1:0];
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (op_reg == ffea_pkg::OP_ALLOC) begin
                    if (rd_data.length >= size_reg) begin
                        ga_next = rd_data.start;
                        if (rd_data.length == size_reg) begin
                            pos_next = count_reg - CW'(1);
                            state_next = S_SHL;
                        end else begin
                            wr_en = 1'b1;
                            wr_data.start = rd_data.start + size_reg[AW-1:0];
                            wr_data.length = rd_data.length - size_reg;
                            state_next = S_OUT;
                        end
                    end else if (idx_reg + CW'(1) >= count_reg) begin
                        st_next = ffea_pkg::ST_NO_SPACE;
                        state_next = S_OUT;
                    end else begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_SCAN;
                    end
                end else if (!phase_reg) begin
                    if ({2'b0, addr_reg} < ext_end && {2'b0, rd_data.start} < rel_end) begin
                        st_next = ffea_pkg::ST_BAD_RELEASE;
                        state_next = S_OUT;
                    end else if (idx_reg + CW'(1) >= count_reg) begin
                        phase_next = 1'b1;
                        idx_next = '0;
                        state_next = S_SCAN;
                    end else begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_SCAN;
                    end
                end else begin
                    if (rd_data.start < addr_reg) begin
                        prevlen_next = ext_end;
                        if (idx_reg + CW'(1) >= count_reg) begin
                            pos_next = count_reg;
                            jp_next = (ext_end == {2'b0, addr_reg});
                            state_next = S_DECIDE;
                        end else begin
                            idx_next = idx_reg + CW'(1);
                            state_next = S_SCAN;
                        end
                    end else begin
                        pos_next = idx_reg;
                        jp_next = (idx_reg != '0) && (prevlen_reg == {2'b0, addr_reg});
                        state_next = S_NEXTR;
                    end
                end
            end
            S_NEXTR: begin
                // rd_data still holds entry pos (read address unchanged)
                rd_addr = pos_reg[IW-1:0];
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                // rd_data = entry pos when pos < count
                if (pos_reg < count_reg && {2'b0, rd_data.start} == rel_end) begin
                    if (jp_reg) begin
                        // merged length into pos-1, then drop pos
                        prevlen_next = {1'b0, size_reg} + {1'b0, rd_data.length};
                        rd_addr = IW'(pos_reg - CW'(1));
                        state_next = S_PREVR;
                    end else begin
                        wr_en = 1'b1;
                        wr_addr = pos_reg[IW-1:0];
                        wr_data.start = addr_reg;
                        wr_data.length = rd_data.length + size_reg;
                        state_next = S_OUT;
                    end
                end else if (jp_reg) begin
                    prevlen_next = {1'b0, size_reg};
                    rd_addr = IW'(pos_reg - CW'(1));
                    state_next = S_PREVR;
                    pos_next = pos_reg;
                    idx_next = '1; // marks "no drop"
                end else if (count_reg >= CW'(ffea_pkg::MAX_EXTENTS)) begin
                    st_next = ffea_pkg::ST_TABLE_FULL;
                    state_next = S_OUT;
                end else begin
                    ins_next.start = addr_reg;
                    ins_next.length = size_reg;
                    idx_next = count_reg;
                    count_next = count_reg + CW'(1);
                    state_next = (count_reg == pos_reg) ? S_SHRW : S_SHR;
                end
            end
            S_PREVR: begin
                rd_addr = IW'(pos_reg - CW'(1));
                if (idx_reg == '1 && state_reg == S_PREVR && phase_reg) begin
                    phase_next = 1'b0;
                    wr_en = 1'b1;
                    wr_addr = IW'(pos_reg - CW'(1));
                    wr_data.length = rd_data.length + prevlen_reg[SW-1:0];
                    state_next = S_OUT;
                end else if (phase_reg) begin
                    phase_next = 1'b0;
                    wr_en = 1'b1;
                    wr_addr = IW'(pos_reg - CW'(1));
                    wr_data.length = rd_data.length + prevlen_reg[SW-1:0];
                    idx_next = pos_reg;
                    pos_next = count_reg - CW'(1);
                    state_next = S_SHL;
                end else begin
                    phase_next = 1'b1; // wait for read data
                end
            end
            S_SHL: begin
                // move idx+1 down to idx, until idx reaches count-1
                if (idx_reg >= pos_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_OUT;
                end else begin
                    rd_addr = IW'(idx_reg + CW'(1));
                    state_next = S_SHLW;
                end
            end
            S_SHLW: begin
                wr_en = 1'b1;
                wr_addr = idx_reg[IW-1:0];
                idx_next = idx_reg + CW'(1);
                state_next = S_SHL;
            end
            S_SHR: begin
                rd_addr = IW'(idx_reg - CW'(1));
                state_next = S_SHRW;
            end
            S_SHRW: begin
                wr_en = 1'b1;
                wr_addr = idx_reg[IW-1:0];
                if (idx_reg == pos_reg) begin
                    wr_data = ins_reg;
                    state_next = S_OUT;
                end else begin
                    idx_next = idx_reg - CW'(1);
                    state_next = (idx_reg - CW'(1) == pos_reg) ? S_SHRW : S_SHR;
                end
            end
            S_OUT: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_OUT && st_next != ffea_pkg::ST_OK) ga_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            mv_reg    <= 1'b0;
            init_reg  <= 1'b1;
            phase_reg <= 1'b0;
        end else begin
            init_reg  <= 1'b0;
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (state_reg == S_OUT) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            addr_reg <= s_block_address;
            size_reg <= s_block_size;
        end
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        jp_reg      <= jp_next;
        prevlen_reg <= prevlen_next;
        ins_reg     <= ins_next;
        st_reg      <= st_next;
        ga_reg      <= (st_next == ffea_pkg::ST_OK) ? ga_next : '0;
    end

    `FFEA_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, s_valid && s_ready, !m_valid, "item accepted while result pending")
    `FFEA_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= CW'(ffea_pkg::MAX_EXTENTS), "extent count out of range")
    `FFEA_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_valid && m_status != ffea_pkg::ST_OK, m_granted_address == '0, "granted address nonzero on failure")
endmodule
`default_nettype wire
